### sv/mipid_pkg.sv
// Package with the shared types, widths and register codes of the incremental PID block.
`timescale 1ns / 1ps

package mipid_pkg;

    localparam int DEF_CHANNELS       = 3;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int DATA_W = 16;
    localparam int ERR_W  = 17;
    localparam int PROD_W = DATA_W + ERR_W;
    localparam int ACC_W  = 36;

    localparam logic [1:0] CFG_GAIN_CURRENT = 2'd0;
    localparam logic [1:0] CFG_GAIN_LAST    = 2'd1;
    localparam logic [1:0] CFG_GAIN_OLDER   = 2'd2;

    typedef struct packed {
        logic [1:0]               channel;
        logic signed [DATA_W-1:0] reference_speed;
        logic signed [DATA_W-1:0] measured_speed;
        logic signed [DATA_W-1:0] previous_drive;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clipped;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_current;
        logic signed [DATA_W-1:0] gain_last;
        logic signed [DATA_W-1:0] gain_older;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [ERR_W-1:0]  last_err;
        logic signed [ERR_W-1:0]  older_err;
        logic signed [DATA_W-1:0] prev;
        logic                     ref_zero;
    } t_hist_stage;

    typedef struct packed {
        logic signed [PROD_W-1:0] p_current;
        logic signed [PROD_W-1:0] p_last;
        logic signed [PROD_W-1:0] p_older;
        logic signed [DATA_W-1:0] prev;
        logic                     ref_zero;
    } t_prod_stage;

endpackage

### sv/mipid_hist.sv
// Input stage: error calculation and per-channel error history.
`timescale 1ns / 1ps

module mipid_hist
    import mipid_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    input  logic        i_next_ready,
    output logic        o_valid,
    output t_hist_stage o_stage
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [ERR_W-1:0] r_last  [CHANNELS];
    logic signed [ERR_W-1:0] r_older [CHANNELS];
    logic                    r_valid;
    t_hist_stage             r_stage;
    t_hist_stage             n_stage;
    logic [3:0]              ch_ext;
    logic [IDX_W-1:0]        idx;
    logic signed [ERR_W-1:0] err;
    logic                    take;

    assign o_ready = !r_valid || i_next_ready;
    assign take    = i_valid && o_ready;
    assign ch_ext  = 4'(i_item.channel);
    assign idx     = (ch_ext >= 4'(CHANNELS)) ? IDX_W'(CHANNELS - 1) : IDX_W'(ch_ext);
    assign err     = ERR_W'(i_item.reference_speed) - ERR_W'(i_item.measured_speed);

    always_comb begin
        n_stage.err       = err;
        n_stage.last_err  = r_last[idx];
        n_stage.older_err = r_older[idx];
        n_stage.prev      = i_item.previous_drive;
        n_stage.ref_zero  = (i_item.reference_speed == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_last[k]  <= '0;
                r_older[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_last[idx]  <= err;
                r_older[idx] <= r_last[idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### sv/mipid_mult.sv
// Product stage: the three gain multiplications.
`timescale 1ns / 1ps

module mipid_mult
    import mipid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_hist_stage i_stage,
    input  t_gains      i_gains,
    input  logic        i_next_ready,
    output logic        o_valid,
    output t_prod_stage o_stage
);

    logic        r_valid;
    t_prod_stage r_stage;
    t_prod_stage n_stage;

    assign o_ready = !r_valid || i_next_ready;

    always_comb begin
        n_stage.p_current = PROD_W'(i_gains.gain_current) * PROD_W'(i_stage.err);
        n_stage.p_last    = PROD_W'(i_gains.gain_last) * PROD_W'(i_stage.last_err);
        n_stage.p_older   = PROD_W'(i_gains.gain_older) * PROD_W'(i_stage.older_err);
        n_stage.prev      = i_stage.prev;
        n_stage.ref_zero  = i_stage.ref_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### sv/mipid_sat.sv
// Output stage: sum, scaling toward zero, saturation and the result register.
`timescale 1ns / 1ps

module mipid_sat
    import mipid_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_prod_stage i_stage,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);

    localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
    localparam logic signed [ACC_W-1:0] MAX_OUT = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] MIN_OUT = -ACC_W'(32768);

    logic                    r_valid;
    t_out_item               r_item;
    t_out_item               n_item;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] quot;

    assign o_ready = !r_valid || !i_out_stall;

    assign acc  = ACC_W'(i_stage.p_current) + ACC_W'(i_stage.p_last)
                + ACC_W'(i_stage.p_older) + (ACC_W'(i_stage.prev) <<< COEF_FRAC_BITS);
    assign quot = (acc + (acc[ACC_W-1] ? BIAS : ACC_W'(0))) >>> COEF_FRAC_BITS;

    always_comb begin
        if (i_stage.ref_zero) begin
            n_item.drive   = '0;
            n_item.clipped = 1'b0;
        end else if (quot > MAX_OUT) begin
            n_item.drive   = DATA_W'(MAX_OUT);
            n_item.clipped = 1'b1;
        end else if (quot < MIN_OUT) begin
            n_item.drive   = DATA_W'(MIN_OUT);
            n_item.clipped = 1'b1;
        end else begin
            n_item.drive   = DATA_W'(quot);
            n_item.clipped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

### sv/multichannel_incremental_pid.sv
// Top level of the multichannel velocity-form PID controller.
`timescale 1ns / 1ps

// The block takes one transaction per clock while o_in_stall is low, and returns one result
// per transaction, in order. A result passes through the input stage register, the product
// stage register and the output register, and is taken when the output is not stalled. The
// error history of each channel is updated when the transaction is accepted, so transactions
// for the same channel may follow each other in consecutive cycles. The pipeline has an input
// stage that forms the error and reads the channel history, a stage with the three gain
// multipliers, and a stage that sums, scales toward zero and saturates into the output
// register. Gains should be written only while no transaction is in flight.
module multichannel_incremental_pid
    import mipid_pkg::*;
#(
    parameter int CHANNELS       = DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    t_gains      r_gains;
    logic        hist_ready;
    logic        hist_valid;
    t_hist_stage hist_stage;
    logic        mult_ready;
    logic        mult_valid;
    t_prod_stage mult_stage;
    logic        sat_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !hist_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN_CURRENT: r_gains.gain_current <= i_cfg_data;
                CFG_GAIN_LAST:    r_gains.gain_last    <= i_cfg_data;
                CFG_GAIN_OLDER:   r_gains.gain_older   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mipid_hist #(
        .CHANNELS (CHANNELS)
    ) u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (hist_ready),
        .i_item       (i_in_item),
        .i_next_ready (mult_ready),
        .o_valid      (hist_valid),
        .o_stage      (hist_stage)
    );

    mipid_mult u_mult (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (hist_valid),
        .o_ready      (mult_ready),
        .i_stage      (hist_stage),
        .i_gains      (r_gains),
        .i_next_ready (sat_ready),
        .o_valid      (mult_valid),
        .o_stage      (mult_stage)
    );

    mipid_sat #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mult_valid),
        .o_ready     (sat_ready),
        .i_stage     (mult_stage),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the multichannel incremental PID with directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
    import mipid_pkg::*;

    localparam int         NUM_CH      = DEF_CHANNELS;
    localparam int         FRAC_BITS   = DEF_COEF_FRAC_BITS;
    localparam longint     SCALE       = longint'(1) << FRAC_BITS;
    localparam longint     DRIVE_MAX   = 32767;
    localparam longint     DRIVE_MIN   = -32768;
    localparam int         RAND_ITEMS  = 1650;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_item;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_data  = '0;

    logic signed [DATA_W-1:0] gain_cur;
    logic signed [DATA_W-1:0] gain_lst;
    logic signed [DATA_W-1:0] gain_old;
    logic signed [ERR_W-1:0]  last_err [NUM_CH];
    logic signed [ERR_W-1:0]  older_err [NUM_CH];
    t_out_item                pending_drives [$];
    int                       error_count = 0;
    int                       cycle_count = 0;
    bit                       quiet       = 1'b0;

    multichannel_incremental_pid dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 15);
        end
    end

    function automatic t_out_item compute_drive(input t_in_item it);
        int        ch;
        longint    err;
        longint    acc;
        longint    q;
        t_out_item res;
        ch  = (int'(it.channel) >= NUM_CH) ? NUM_CH - 1 : int'(it.channel);
        err = longint'($signed(it.reference_speed)) - longint'($signed(it.measured_speed));
        acc = longint'(gain_cur) * err
            + longint'(gain_lst) * longint'(last_err[ch])
            + longint'(gain_old) * longint'(older_err[ch])
            + longint'($signed(it.previous_drive)) * SCALE;
        q = acc / SCALE;
        res.clipped = 1'b0;
        if (q > DRIVE_MAX) begin
            q = DRIVE_MAX;
            res.clipped = 1'b1;
        end else if (q < DRIVE_MIN) begin
            q = DRIVE_MIN;
            res.clipped = 1'b1;
        end
        res.drive = DATA_W'(q);
        older_err[ch] = last_err[ch];
        last_err[ch]  = ERR_W'(err);
        if ($signed(it.reference_speed) == 0) begin
            res.drive   = '0;
            res.clipped = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_drives.size() == 0) begin
                $error("unexpected result: drive %0d, clipped %0b",
                       $signed(o_out_item.drive), o_out_item.clipped);
                error_count++;
            end else begin
                want = pending_drives.pop_front();
                if (o_out_item.drive !== want.drive) begin
                    $error("drive: expected %0d, actual %0d",
                           $signed(want.drive), $signed(o_out_item.drive));
                    error_count++;
                end
                if (o_out_item.clipped !== want.clipped) begin
                    $error("clipped: expected %0b, actual %0b",
                           want.clipped, o_out_item.clipped);
                    error_count++;
                end
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] ch,
                                           input logic signed [DATA_W-1:0] ref_speed,
                                           input logic signed [DATA_W-1:0] meas_speed,
                                           input logic signed [DATA_W-1:0] prev_drive);
        t_in_item it;
        it.channel         = ch;
        it.reference_speed = ref_speed;
        it.measured_speed  = meas_speed;
        it.previous_drive  = prev_drive;
        return it;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            1, 2, 3, 4: return DATA_W'($urandom);
            default:    return DATA_W'($urandom_range(400)) - 16'd200;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.channel         = 2'($urandom_range(3));
        it.reference_speed = rand_value();
        it.measured_speed  = rand_value();
        it.previous_drive  = rand_value();
        if ($urandom_range(11) == 0) begin
            it.reference_speed = '0;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if (!quiet && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_drives.push_back(compute_drive(it));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_gains(input logic [DATA_W-1:0] g_cur, input logic [DATA_W-1:0] g_lst,
                              input logic [DATA_W-1:0] g_old, input bit with_stray);
        logic [1:0]        idx [4];
        logic [DATA_W-1:0] val [4];
        int                n;
        idx = '{CFG_GAIN_CURRENT, CFG_GAIN_LAST, CFG_GAIN_OLDER, CFG_UNUSED};
        val = '{g_cur, g_lst, g_old, DATA_W'($urandom)};
        n   = with_stray ? 4 : 3;
        drain();
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                CFG_GAIN_CURRENT: gain_cur = val[k];
                CFG_GAIN_LAST:    gain_lst = val[k];
                CFG_GAIN_OLDER:   gain_old = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_zero_gains();
        send_item(make_item(2'd0, 16'sd100, -16'sd50, 16'sh7FFF));
        send_item(make_item(2'd1, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_item(make_item(2'd3, -16'sd1, 16'sd1, -16'sd1));
        send_item(make_item(2'd2, 16'sd0, 16'sd500, 16'sd1234));
    endtask

    task automatic test_saturation();
        load_gains(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
        send_item(make_item(2'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
        send_item(make_item(2'd0, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_item(make_item(2'd1, 16'sd0, 16'sh8000, 16'sh7FFF));
        send_item(make_item(2'd1, 16'sd1, 16'sd0, 16'sd0));
        send_item(make_item(2'd0, 16'sd5, 16'sd5, 16'sd100));
        load_gains(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
        send_item(make_item(2'd0, 16'sh7FFF, 16'sh8000, 16'sh8000));
        send_item(make_item(2'd3, 16'sh8000, 16'sh7FFF, 16'sh7FFF));
    endtask

    task automatic test_channel_history();
        load_gains(16'd4096, -16'sd4096, 16'd2048, 1'b0);
        send_item(make_item(2'd2, 16'sd300, 16'sd100, 16'sd0));
        send_item(make_item(2'd3, 16'sd0, 16'sd50, 16'sd10));
        send_item(make_item(2'd3, 16'sd200, 16'sd250, 16'sd20));
        send_item(make_item(2'd2, 16'sd10, 16'sd10, -16'sd5));
        send_item(make_item(2'd1, -16'sd700, 16'sd300, 16'sd40));
    endtask

    task automatic test_truncation();
        load_gains(16'd1, -16'sd1, 16'd3, 1'b0);
        send_item(make_item(2'd0, -16'sd1, 16'sd0, 16'sd0));
        send_item(make_item(2'd0, 16'sd1, 16'sd0, -16'sd2));
        send_item(make_item(2'd0, 16'sd2, 16'sd4, 16'sd7));
        send_item(make_item(2'd1, 16'sh7FFF, 16'sh8000, 16'sd0));
    endtask

    task automatic test_stray_register();
        load_gains(16'd2048, 16'd1024, -16'sd512, 1'b1);
        send_item(make_item(2'd0, 16'sd1000, 16'sd0, 16'sd0));
        send_item(make_item(2'd1, -16'sd1000, 16'sd24, -16'sd300));
        send_item(make_item(2'd2, 16'sd77, -16'sd77, 16'sd5));
    endtask

    task automatic test_random_mix();
        t_gains sets [6];
        int     per_phase;
        sets[0]   = '{16'sd4096, -16'sd4096, 16'sd1024};
        sets[1]   = '{16'sd3000, -16'sd2500, 16'sd800};
        sets[2]   = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
        sets[3]   = '{16'sh8000, 16'sh8000, 16'sh8000};
        sets[4]   = '{DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom)};
        sets[5]   = '{DATA_W'($urandom_range(8191)) - 16'd4096,
                      DATA_W'($urandom_range(8191)) - 16'd4096,
                      DATA_W'($urandom_range(8191)) - 16'd4096};
        per_phase = RAND_ITEMS / 6;
        for (int p = 0; p < 6; p++) begin
            load_gains(sets[p].gain_current, sets[p].gain_last, sets[p].gain_older, p[0]);
            quiet = (p == 1);
            for (int i = 0; i < per_phase; i++) begin
                if (i == per_phase / 2) begin
                    drain();
                end
                send_item(rand_item());
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        gain_cur = '0;
        gain_lst = '0;
        gain_old = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            last_err[k]  = '0;
            older_err[k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_gains();
        test_saturation();
        test_channel_history();
        test_truncation();
        test_stray_register();
        test_random_mix();
        drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending_drives.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
